[hw/rtl/jfd_pkg.sv]
// Shared types and constants of the JPEG frame delimiter.
package jfd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned SKIP_W    = 16;
    localparam int unsigned MAX_RES   = 3;
    localparam int unsigned QUEUE_D   = 4;
    localparam int unsigned QCNT_W    = 3;

    localparam logic [BYTE_W-1:0] MK_PREFIX = 8'hFF;
    localparam logic [BYTE_W-1:0] MK_SOI    = 8'hD8;
    localparam logic [BYTE_W-1:0] MK_SOS    = 8'hDA;
    localparam logic [BYTE_W-1:0] MK_DRI    = 8'hDD;
    localparam logic [BYTE_W-1:0] MK_RST0   = 8'hD0;
    localparam logic [BYTE_W-1:0] MK_RST7   = 8'hD7;
    localparam logic [BYTE_W-1:0] MK_EOI    = 8'hD9;

    localparam logic [SKIP_W-1:0] DRI_SKIP  = 16'd4;
    localparam logic [SKIP_W-1:0] LEN_MIN   = 16'd2;

    typedef enum logic [6:0] {
        PH_PREFIX = 7'b0000001,
        PH_CODE   = 7'b0000010,
        PH_LENHI  = 7'b0000100,
        PH_LENLO  = 7'b0001000,
        PH_SKIP   = 7'b0010000,
        PH_SCAN   = 7'b0100000,
        PH_DROP   = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              frame_end;
        logic              bad_frame;
    } result_t;

    // Words produced by one accepted input byte; res[0] goes out first.
    typedef struct packed {
        logic [1:0]              count;
        result_t [MAX_RES-1:0]   res;
    } gen_t;

endpackage

[hw/rtl/jfd_parser.sv]
// Marker walker: parse state and the words made for each accepted byte.
module jfd_parser (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [jfd_pkg::BYTE_W-1:0] data_byte,
    input  logic                     buffer_end,
    output jfd_pkg::gen_t            gen
);
    import jfd_pkg::*;

    phase_t            phase_reg, phase_next;
    logic              scan_reg, scan_next;
    logic [BYTE_W-1:0] len_hi_reg, len_hi_next;
    logic [SKIP_W-1:0] skip_reg, skip_next;
    logic              prev_ff_reg, prev_ff_next;

    logic              closed;
    logic [SKIP_W-1:0] seg_len;
    logic [SKIP_W-1:0] skip_dec;
    gen_t              g;

    assign seg_len  = {len_hi_reg, data_byte};
    assign skip_dec = (skip_reg != '0) ? skip_reg - 1'b1 : skip_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        scan_next    = scan_reg;
        len_hi_next  = len_hi_reg;
        skip_next    = skip_reg;
        prev_ff_next = prev_ff_reg;
        closed       = 1'b0;
        g            = '0;
        g.res[0]     = '{out_byte: data_byte, frame_end: 1'b0, bad_frame: 1'b0};
        g.count      = 2'd1;

        case (phase_reg)
            PH_PREFIX:
            begin
                if (data_byte != MK_PREFIX)
                begin
                    g.res[0].frame_end = 1'b1;
                    g.res[0].bad_frame = 1'b1;
                    closed     = 1'b1;
                    phase_next = PH_DROP;
                end
                else
                begin
                    phase_next = PH_CODE;
                end
            end
            PH_CODE:
            begin
                if (data_byte == MK_EOI)
                begin
                    g.res[0].frame_end = 1'b1;
                    closed     = 1'b1;
                    phase_next = PH_DROP;
                end
                else if (data_byte == MK_SOI ||
                         (data_byte >= MK_RST0 && data_byte <= MK_RST7))
                begin
                    phase_next = PH_PREFIX;
                end
                else if (data_byte == MK_DRI)
                begin
                    scan_next  = 1'b0;
                    skip_next  = DRI_SKIP;
                    phase_next = PH_SKIP;
                end
                else
                begin
                    scan_next  = (data_byte == MK_SOS);
                    phase_next = PH_LENHI;
                end
            end
            PH_LENHI:
            begin
                len_hi_next = data_byte;
                phase_next  = PH_LENLO;
            end
            PH_LENLO:
            begin
                // saturate short lengths so nothing is skipped
                skip_next = (seg_len < LEN_MIN) ? '0 : seg_len - LEN_MIN;
                if (skip_next == '0)
                begin
                    if (scan_reg)
                    begin
                        phase_next   = PH_SCAN;
                        prev_ff_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_PREFIX;
                    end
                end
                else
                begin
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    if (scan_reg)
                    begin
                        phase_next   = PH_SCAN;
                        prev_ff_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_PREFIX;
                    end
                end
            end
            PH_SCAN:
            begin
                if (prev_ff_reg && data_byte == MK_EOI)
                begin
                    g.res[0].frame_end = 1'b1;
                    closed     = 1'b1;
                    phase_next = PH_DROP;
                end
                else
                begin
                    prev_ff_next = (data_byte == MK_PREFIX);
                end
            end
            default:
            begin
                // dropping trailing bytes
                g.count = 2'd0;
                closed  = 1'b1;
            end
        endcase

        if (buffer_end)
        begin
            if (!closed)
            begin
                // close an unterminated frame with an appended EOI
                g.res[1] = '{out_byte: MK_PREFIX, frame_end: 1'b0, bad_frame: 1'b0};
                g.res[2] = '{out_byte: MK_EOI, frame_end: 1'b1, bad_frame: 1'b0};
                g.count  = 2'd3;
            end
            phase_next   = PH_PREFIX;
            scan_next    = 1'b0;
            len_hi_next  = '0;
            skip_next    = '0;
            prev_ff_next = 1'b0;
        end

        if (!in_valid)
        begin
            g.count = 2'd0;
        end
    end

    assign gen = g;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_PREFIX;
            scan_reg    <= 1'b0;
            len_hi_reg  <= '0;
            skip_reg    <= '0;
            prev_ff_reg <= 1'b0;
        end
        else if (in_valid)
        begin
            phase_reg   <= phase_next;
            scan_reg    <= scan_next;
            len_hi_reg  <= len_hi_next;
            skip_reg    <= skip_next;
            prev_ff_reg <= prev_ff_next;
        end
    end

endmodule

[hw/rtl/jpeg_frame_delimiter_core.sv]
// Top level of the JPEG frame delimiter: parser plus a four-word output queue.
// Takes an MJPEG capture buffer one byte per word and passes on the bytes of
// one JPEG image, from the start of the buffer up to and including the D9 of
// EOI (frame_end on tlast); everything after it is dropped. A non-FF byte where
// a marker is due ends the frame with bad_frame (tuser) set on that byte. A
// buffer whose last byte (tlast on input) leaves the frame open gets FF D9
// appended. The block takes one byte per clock while s_tready is high: each byte
// makes at most one output word, except the closing byte of an unterminated
// buffer, which makes three. Input ready depends only on the fill of the
// four-word output queue (ready while it holds at most one word), so with the
// output draining freely the block runs at one byte per cycle and pauses only
// after an unterminated buffer end. Result words are registered into the queue.
module jpeg_frame_delimiter_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // buffer_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // [0] bad_frame
    output logic       m_tlast    // frame_end
);
    import jfd_pkg::*;

    logic              accept;
    logic              pop;
    gen_t              gen;

    result_t           q_reg [QUEUE_D];
    result_t           q_next [QUEUE_D];
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic [QCNT_W-1:0] base;

    assign s_tready = (cnt_reg <= QCNT_W'(1));
    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = (cnt_reg != '0);
    assign pop      = m_tvalid & m_tready;

    assign m_tdata  = q_reg[0].out_byte;
    assign m_tlast  = q_reg[0].frame_end;
    assign m_tuser  = q_reg[0].bad_frame;

    jfd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .data_byte  (s_tdata),
        .buffer_end (s_tlast),
        .gen        (gen)
    );

    // Advance the queue on a pop, then append the new words behind what is left.
    always_comb
    begin
        base = cnt_reg - QCNT_W'(pop);
        for (int j = 0; j < QUEUE_D; j++)
            q_next[j] = q_reg[j];
        if (pop)
        begin
            for (int j = 0; j < QUEUE_D - 1; j++)
                q_next[j] = q_reg[j + 1];
        end
        for (int j = 0; j < QUEUE_D; j++)
        begin
            for (int i = 0; i < MAX_RES; i++)
            begin
                if (QCNT_W'(i) < QCNT_W'(gen.count) &&
                    base + QCNT_W'(i) == QCNT_W'(j))
                    q_next[j] = gen.res[i];
            end
        end
        cnt_next = base + QCNT_W'(gen.count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < QUEUE_D; j++)
            q_reg[j] <= q_next[j];
    end

endmodule

[hw/rtl/jfd_checker.sv]
// Port-level checks of the JPEG frame delimiter and their bind.
module jfd_port_props (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);
    import jfd_pkg::*;

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
        $stable(m_tlast) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // a broken frame always ends on that word
    a_bad_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("bad_frame without frame_end");

    // a clean frame ends on the D9 of EOI
    a_eoi_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && !m_tuser |-> m_tdata == MK_EOI)
        else $error("clean frame end is not EOI");

    // the offending byte is never a marker prefix
    a_bad_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata != MK_PREFIX)
        else $error("bad_frame on an FF byte");

    // input stalls only behind queued words
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with nothing queued");

endmodule

bind jpeg_frame_delimiter_core jfd_port_props u_jfd_checker (.*);

[sim/jfd_checker.sv]
`timescale 1ns / 100ps
// Byte-stream monitor for the JPEG frame delimiter: walks markers, checks each output word.
module jfd_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [jfd_pkg::BYTE_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic                       s_tlast,   // buffer_end
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [jfd_pkg::BYTE_W-1:0] m_tdata,   // [7:0] out_byte
    input  logic                       m_tuser,   // [0] bad_frame
    input  logic                       m_tlast,   // frame_end
    output int                         mismatch_count,
    output int                         words_owed
);
    import jfd_pkg::*;

    // Image bytes still owed by the block, oldest first.
    result_t           image_bytes_due[$];
    result_t           want;

    // Marker walk state.
    phase_t            phase;
    logic              in_scan;
    logic [BYTE_W-1:0] len_hi;
    logic [SKIP_W-1:0] skip_left;
    logic              saw_ff;

    initial mismatch_count = 0;

    task automatic walk_reset();
        phase     = PH_PREFIX;
        in_scan   = 1'b0;
        len_hi    = '0;
        skip_left = '0;
        saw_ff    = 1'b0;
    endtask

    task automatic owe(input logic [BYTE_W-1:0] b, input logic fe, input logic bad);
        result_t w;
        w.out_byte  = b;
        w.frame_end = fe;
        w.bad_frame = bad;
        image_bytes_due.push_back(w);
    endtask

    // Segment body done: enter entropy data after SOS, else expect a marker.
    task automatic leave_skip();
        if (in_scan)
        begin
            phase  = PH_SCAN;
            saw_ff = 1'b0;
        end
        else
            phase = PH_PREFIX;
    endtask

    task automatic walk_marker_byte(input logic [BYTE_W-1:0] b, input logic last);
        logic              closed;
        logic [SKIP_W-1:0] seg_len;
        closed = 1'b0;
        case (phase)
            PH_PREFIX:
                if (b != MK_PREFIX)
                begin
                    owe(b, 1'b1, 1'b1);
                    closed = 1'b1;
                    phase  = PH_DROP;
                end
                else
                begin
                    owe(b, 1'b0, 1'b0);
                    phase = PH_CODE;
                end
            PH_CODE:
                if (b == MK_EOI)
                begin
                    owe(b, 1'b1, 1'b0);
                    closed = 1'b1;
                    phase  = PH_DROP;
                end
                else
                begin
                    owe(b, 1'b0, 1'b0);
                    if (b == MK_SOI || (b >= MK_RST0 && b <= MK_RST7))
                        phase = PH_PREFIX;
                    else if (b == MK_DRI)
                    begin
                        in_scan   = 1'b0;
                        skip_left = DRI_SKIP;
                        phase     = PH_SKIP;
                    end
                    else
                    begin
                        in_scan = (b == MK_SOS);
                        phase   = PH_LENHI;
                    end
                end
            PH_LENHI:
            begin
                owe(b, 1'b0, 1'b0);
                len_hi = b;
                phase  = PH_LENLO;
            end
            PH_LENLO:
            begin
                owe(b, 1'b0, 1'b0);
                seg_len = {len_hi, b};
                if (seg_len < LEN_MIN)
                    seg_len = LEN_MIN;
                skip_left = seg_len - LEN_MIN;
                if (skip_left == 0)
                    leave_skip();
                else
                    phase = PH_SKIP;
            end
            PH_SKIP:
            begin
                owe(b, 1'b0, 1'b0);
                if (skip_left != 0)
                    skip_left = skip_left - 1'b1;
                if (skip_left == 0)
                    leave_skip();
            end
            PH_SCAN:
                if (saw_ff && b == MK_EOI)
                begin
                    owe(b, 1'b1, 1'b0);
                    closed = 1'b1;
                    phase  = PH_DROP;
                end
                else
                begin
                    owe(b, 1'b0, 1'b0);
                    saw_ff = (b == MK_PREFIX);
                end
            default:
                closed = 1'b1;
        endcase
        if (last)
        begin
            if (!closed)
            begin
                owe(MK_PREFIX, 1'b0, 1'b0);
                owe(MK_EOI, 1'b1, 1'b0);
            end
            walk_reset();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reset();
            image_bytes_due.delete();
            words_owed = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                walk_marker_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (image_bytes_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected word: expected none, actual %02h last %b user %b",
                             $time, m_tdata, m_tlast, m_tuser);
                end
                else
                begin
                    want = image_bytes_due.pop_front();
                    if (m_tdata !== want.out_byte)
                    begin
                        mismatch_count++;
                        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                                 $time, want.out_byte, m_tdata);
                    end
                    if (m_tlast !== want.frame_end)
                    begin
                        mismatch_count++;
                        $display("%0t: frame_end mismatch: expected %b, actual %b",
                                 $time, want.frame_end, m_tlast);
                    end
                    if (m_tuser !== want.bad_frame)
                    begin
                        mismatch_count++;
                        $display("%0t: bad_frame mismatch: expected %b, actual %b",
                                 $time, want.bad_frame, m_tuser);
                    end
                end
            end
            words_owed = image_bytes_due.size();
        end
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// Testbench top for the JPEG frame delimiter: clock, reset, capture-buffer stimulus and verdict.
module tb;
    import jfd_pkg::*;

    // Marker codes outside the package that the stimulus uses.
    localparam logic [BYTE_W-1:0] MK_DHT  = 8'hC4;

    localparam int unsigned RAND_BYTES  = 110;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_START  = 300;   // cycle at which the long stall begins
    localparam int unsigned HOLD_LEN    = 64;    // long stall length in cycles
    localparam int unsigned DRAIN_WAIT  = 8;     // cycles to idle after the last word

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata;    // [7:0] data_byte
    logic              s_tlast;    // buffer_end
    logic              m_tvalid;
    logic              m_tready;
    logic [BYTE_W-1:0] m_tdata;    // [7:0] out_byte
    logic              m_tuser;    // [0] bad_frame
    logic              m_tlast;    // frame_end

    int                mismatch_count;
    int                words_owed;
    int                cycle_count;
    int                bytes_sent;
    logic              send_burst;
    logic [BYTE_W-1:0] frame_bytes[$];

    jpeg_frame_delimiter_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    jfd_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .words_owed     (words_owed)
    );

    // 12 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Count cycles and bail out if the run hangs.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offer one word on the input side after a random gap; return at the falling
    // edge after it is taken, with tvalid still high so back-to-back words
    // follow without a gap.
    task automatic send_word(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Send the staged capture buffer, marking its final byte with tlast.
    task automatic send_frame();
        int i;
        send_burst = ($urandom_range(0, 3) == 0);
        for (i = 0; i < frame_bytes.size(); i++)
            send_word(frame_bytes[i], i == frame_bytes.size() - 1);
        frame_bytes.delete();
    endtask

    task automatic push_random(input int n);
        repeat (n) frame_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
    endtask

    // Stage a random capture buffer. Most are well-formed images with random
    // segment content; the rest are noise, a stray byte where a marker is due,
    // or images cut short before EOI.
    task automatic build_random_frame();
        int                kind;
        int                n;
        int                seg_len;
        logic              broken;
        logic [BYTE_W-1:0] code;
        kind = $urandom_range(0, 9);
        if (kind == 0)
            push_random($urandom_range(1, 6));
        else
        begin
            broken = (kind == 1);
            frame_bytes.push_back(MK_PREFIX);
            frame_bytes.push_back(MK_SOI);
            repeat ($urandom_range(0, 3))
            begin
                // Break the structure with a non-FF byte where a marker is due.
                if (broken && $urandom_range(0, 1) == 0)
                begin
                    frame_bytes.push_back(BYTE_W'($urandom_range(0, 254)));
                    broken = 1'b0;
                end
                case ($urandom_range(0, 3))
                    0:
                    begin
                        frame_bytes.push_back(MK_PREFIX);
                        frame_bytes.push_back(MK_RST0 + BYTE_W'($urandom_range(0, 7)));
                    end
                    1:
                    begin
                        frame_bytes.push_back(MK_PREFIX);
                        frame_bytes.push_back(MK_DRI);
                        push_random(4);
                    end
                    default:
                    begin
                        // Mostly APPn/DQT-like codes; now and then any byte at all.
                        if ($urandom_range(0, 5) == 0)
                            code = BYTE_W'($urandom_range(0, 255));
                        else
                            code = BYTE_W'($urandom_range(8'hC0, 8'hFF));
                        seg_len = $urandom_range(0, 7);
                        frame_bytes.push_back(MK_PREFIX);
                        frame_bytes.push_back(code);
                        frame_bytes.push_back(8'h00);
                        frame_bytes.push_back(BYTE_W'(seg_len));
                        if (seg_len > 2)
                            push_random(seg_len - 2);
                    end
                endcase
            end
            // Scan header, then entropy data rich in FF bytes.
            seg_len = $urandom_range(2, 5);
            frame_bytes.push_back(MK_PREFIX);
            frame_bytes.push_back(MK_SOS);
            frame_bytes.push_back(8'h00);
            frame_bytes.push_back(BYTE_W'(seg_len));
            push_random(seg_len - 2);
            n = $urandom_range(0, 10);
            repeat (n)
            begin
                if ($urandom_range(0, 4) == 0)
                    frame_bytes.push_back(MK_PREFIX);
                else
                    push_random(1);
            end
            // Close most images; leave the rest for the block to terminate.
            if ($urandom_range(0, 9) < 7)
            begin
                frame_bytes.push_back(MK_PREFIX);
                frame_bytes.push_back(MK_EOI);
            end
            // Trailing junk after the image.
            push_random($urandom_range(0, 2));
        end
    endtask

    // Output side: random ready gaps per word, bursts with no gaps, and one long
    // stall so the output queue fills and the block holds off its input.
    initial
    begin
        int   gap;
        int   words_taken;
        logic held;
        logic recv_burst;
        m_tready    = 1'b0;
        held        = 1'b0;
        recv_burst  = 1'b0;
        words_taken = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held && cycle_count >= HOLD_START)
            begin
                m_tready = 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
                held = 1'b1;
            end
            if (words_taken % 32 == 0)
                recv_burst = ($urandom_range(0, 3) == 0);
            gap = recv_burst ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            @(negedge clk);
            words_taken++;
        end
    end

    // Reset, stimulus and verdict.
    initial
    begin
        int rand_start;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        send_burst = 1'b0;
        bytes_sent = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // SOI, RST7, DRI with its four bytes, code FF on the length path with a
        // short length, SOS skipping one byte, then FF FF D9 in the scan and a
        // trailing byte that must be dropped.
        frame_bytes = '{MK_PREFIX, MK_SOI, MK_PREFIX, MK_RST7, MK_PREFIX, MK_DRI,
                        8'h00, 8'hFF, 8'h5A, 8'hA5, MK_PREFIX, MK_PREFIX, 8'h00, 8'h01,
                        MK_PREFIX, MK_SOS, 8'h00, 8'h03, 8'h5A, MK_PREFIX, MK_PREFIX,
                        MK_EOI, 8'hC3};
        send_frame();
        // EOI where a marker is due, on the last byte of the buffer.
        frame_bytes = '{MK_PREFIX, MK_EOI};
        send_frame();
        // Stray byte where a marker prefix is due; the rest is dropped.
        frame_bytes = '{8'h7A, 8'h11};
        send_frame();
        // Buffer ending right after RST0: FF D9 gets appended.
        frame_bytes = '{MK_PREFIX, MK_RST0};
        send_frame();
        // Zero length on a table segment, buffer ends mid-segment.
        frame_bytes = '{MK_PREFIX, MK_DHT, 8'h00, 8'h00, MK_PREFIX, MK_DHT, 8'hFF};
        send_frame();

        rand_start = bytes_sent;
        while (bytes_sent - rand_start < RAND_BYTES)
        begin
            build_random_frame();
            send_frame();
        end
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;

        // Drain: wait for every owed word, then idle for the block's latency.
        wait (words_owed == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0 && words_owed == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/jfd_pkg.sv
hw/rtl/jfd_parser.sv
hw/rtl/jpeg_frame_delimiter_core.sv
hw/rtl/jfd_checker.sv
sim/jfd_checker.sv
sim/tb.sv
